// File: hdl/shifted_image_difference_assert.svh
// assertion macros for the shifted image difference block
// no dependencies; included by the files that carry assertions
`ifndef SHIFTED_IMAGE_DIFFERENCE_ASSERT_SVH
`define SHIFTED_IMAGE_DIFFERENCE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SHID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shid: check failed");

// next-cycle implication
`define SHID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shid: check failed");

`else

`define SHID_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHID_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/shid_pkg.sv
// shared types and constants for the shifted image difference block
// no dependencies
`default_nettype none

package shid_pkg;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y      = 2'd3;

    // register values after reset
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd256;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd256;
    localparam logic [CFG_W-1:0] RST_SHIFT_X      = 11'd1;
    localparam logic [CFG_W-1:0] RST_SHIFT_Y      = 11'd1;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // parameter defaults
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 1024;
    localparam int DEF_HISTORY_DEPTH = 8192;
    localparam int DEF_PIXEL_BITS    = 16;

    // how a transaction gets its result
    typedef enum logic [1:0] {
        MODE_OVF,     // offset beyond the store, zero result
        MODE_BEHIND,  // partner already stored, own pixel is the new one
        MODE_AHEAD,   // partner is the new pixel, own pixel read from the store
        MODE_DRAIN    // flushed result, zero
    } t_mode;

endpackage

`default_nettype wire

// File: hdl/shifted_image_difference.sv
// Shifted image difference: a transaction passes the input, result and output registers
// on its way to the result it causes; throughput one transaction per cycle while nothing stalls,
// set by the single write port and single read port of the history memory.
// Reset (synchronous, active low) restores 256x256 frames and shift (1,1) and clears
// the stream position; history memory contents stay undefined until written.
// Depends on shid_pkg and shifted_image_difference_assert.svh.
`default_nettype none
`include "shifted_image_difference_assert.svh"

module shifted_image_difference #(
    parameter int MAX_WIDTH     = shid_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = shid_pkg::DEF_MAX_HEIGHT,
    parameter int HISTORY_DEPTH = shid_pkg::DEF_HISTORY_DEPTH,
    parameter int PIXEL_BITS    = shid_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [shid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [shid_pkg::CFG_W-1:0]      i_cfg_data,
    // input channel
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_kind,
    input  wire logic signed [PIXEL_BITS-1:0]    i_pixel_value,
    // output channel
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [PIXEL_BITS:0]           o_difference,
    output logic                                 o_frame_last,
    output logic                                 o_offset_overflow
);

    localparam int CW  = shid_pkg::CFG_W;
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int RB  = $clog2(MAX_HEIGHT);
    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int EWW = (WB > CW) ? WB : CW;
    localparam int EWH = (HB > CW) ? HB : CW;
    localparam int LW0 = WB + CW + 2;
    localparam int LW  = (LW0 > AW + 2) ? LW0 : AW + 2;
    localparam int XW  = ((CB > CW) ? CB : CW) + 2;
    localparam int YW  = ((RB > CW) ? RB : CW) + 2;
    localparam logic signed [LW-1:0] DEPTH_S = LW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

    // configuration registers
    logic [CW-1:0] r_frame_width, r_frame_height, r_shift_x, r_shift_y;
    logic          cfg_hit;

    // stream state
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [CB-1:0] r_col, n_col;
    logic [RB-1:0] r_row, n_row;

    // offset registers
    logic                 r_ovf, r_neg;
    logic [AW-1:0]        r_k;

    // pipeline registers
    logic                          r_s0_v;
    logic                          r_s0_kind;
    logic signed [PIXEL_BITS-1:0]  r_s0_pix;
    logic                          r_s2_v;
    shid_pkg::t_mode               r_s2_mode;
    logic signed [PIXEL_BITS-1:0]  r_s2_pix;
    logic signed [PIXEL_BITS-1:0]  r_s2_mem;
    logic                          r_s2_in_frame, r_s2_last, r_s2_fwd;
    logic                          r_out_v;
    logic signed [PIXEL_BITS:0]    r_out_diff;
    logic                          r_out_last, r_out_ovf;

    // history memory
    logic signed [PIXEL_BITS-1:0]  mem [HISTORY_DEPTH];

    // combinational signals
    logic [EWW-1:0]       w_ext;
    logic [EWH-1:0]       h_ext;
    logic [WB-1:0]        w_c;
    logic [HB-1:0]        h_c;
    logic signed [CW-1:0] xs_s, ys_s;
    logic signed [LW-1:0] lin_c;
    logic                 in_acc, step, out_free, s2_free;
    logic                 is_pixel, emit, mem_we;
    logic [AW-1:0]        rd_addr;
    logic signed [XW-1:0] cx;
    logic signed [YW-1:0] ry;
    logic                 in_frame, col_end, row_end, last_c;
    shid_pkg::t_mode      mode_c;
    logic signed [PIXEL_BITS-1:0] own, partner;
    logic signed [PIXEL_BITS:0]   diff_c;
    logic                 diff_live;

    // clamp frame size to 1..max
    always_comb begin
        if (r_frame_width == '0) begin
            w_ext = EWW'(1);
        end else if (EWW'(r_frame_width) > EWW'(MAX_WIDTH)) begin
            w_ext = EWW'(MAX_WIDTH);
        end else begin
            w_ext = EWW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_ext = EWH'(1);
        end else if (EWH'(r_frame_height) > EWH'(MAX_HEIGHT)) begin
            h_ext = EWH'(MAX_HEIGHT);
        end else begin
            h_ext = EWH'(r_frame_height);
        end
    end

    assign w_c  = WB'(w_ext);
    assign h_c  = HB'(h_ext);
    assign xs_s = r_shift_x;
    assign ys_s = r_shift_y;

    // linear offset of the partner pixel
    assign lin_c = LW'(ys_s) * LW'($signed({1'b0, w_c})) + LW'(xs_s);

    always_ff @(posedge i_clk) begin
        r_ovf <= (lin_c >= DEPTH_S) || (lin_c <= -DEPTH_S);
        r_neg <= lin_c[LW-1];
        r_k   <= lin_c[LW-1] ? AW'(-lin_c) : AW'(lin_c);
    end

    // pipeline handshake
    assign out_free = !r_out_v || !i_stall;
    assign s2_free  = !r_s2_v || out_free;
    assign step     = r_s0_v && s2_free;
    assign o_stall  = r_s0_v && !s2_free;
    assign in_acc   = i_valid && !o_stall;

    // step decision for the transaction in the input register
    assign is_pixel = (r_s0_kind == shid_pkg::KIND_PIXEL);
    assign mem_we   = step && is_pixel;

    always_comb begin
        if (!is_pixel) begin
            mode_c = shid_pkg::MODE_DRAIN;
            emit   = (r_cnt != '0);
        end else if (r_ovf) begin
            mode_c = shid_pkg::MODE_OVF;
            emit   = 1'b1;
        end else if (r_neg) begin
            mode_c = shid_pkg::MODE_BEHIND;
            emit   = 1'b1;
        end else begin
            mode_c = shid_pkg::MODE_AHEAD;
            emit   = (r_cnt >= r_k);
        end
    end

    // read slot: r_k places before the write slot, wrapped
    always_comb begin
        if (r_wr_idx >= r_k) begin
            rd_addr = r_wr_idx - r_k;
        end else begin
            rd_addr = AW'({1'b0, r_wr_idx} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, r_k});
        end
    end

    // frame check for the current output position
    assign cx       = XW'($signed({1'b0, r_col})) + XW'(xs_s);
    assign ry       = YW'($signed({1'b0, r_row})) + YW'(ys_s);
    assign in_frame = !cx[XW-1] && (cx < XW'($signed({1'b0, w_c})))
                   && !ry[YW-1] && (ry < YW'($signed({1'b0, h_c})));
    assign col_end  = ({1'b0, WB'(r_col)} + (WB + 1)'(1)) >= {1'b0, w_c};
    assign row_end  = ({1'b0, HB'(r_row)} + (HB + 1)'(1)) >= {1'b0, h_c};
    assign last_c   = col_end && row_end;

    // next stream state
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_cnt    = r_cnt;
        n_col    = r_col;
        n_row    = r_row;
        if (step) begin
            if (is_pixel) begin
                n_wr_idx = (r_wr_idx == LAST_SLOT) ? '0 : r_wr_idx + AW'(1);
                if (mode_c == shid_pkg::MODE_AHEAD && !emit) begin
                    n_cnt = r_cnt + AW'(1);
                end
            end else if (emit) begin
                n_cnt = r_cnt - AW'(1);
            end
            if (emit) begin
                if (col_end) begin
                    n_col = '0;
                    n_row = row_end ? '0 : r_row + RB'(1);
                end else begin
                    n_col = r_col + CB'(1);
                end
            end
        end
    end

    // configuration writes restart the stream
    assign cfg_hit = i_cfg_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= shid_pkg::RST_FRAME_WIDTH;
            r_frame_height <= shid_pkg::RST_FRAME_HEIGHT;
            r_shift_x      <= shid_pkg::RST_SHIFT_X;
            r_shift_y      <= shid_pkg::RST_SHIFT_Y;
            r_wr_idx       <= '0;
            r_cnt          <= '0;
            r_col          <= '0;
            r_row          <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                shid_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                shid_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                shid_pkg::REG_SHIFT_X:      r_shift_x      <= i_cfg_data;
                shid_pkg::REG_SHIFT_Y:      r_shift_y      <= i_cfg_data;
                default:                    r_shift_y      <= r_shift_y;
            endcase
            r_wr_idx <= '0;
            r_cnt    <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_cnt    <= n_cnt;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s0_v  <= in_acc ? 1'b1 : (r_s0_v && !step);
            r_s2_v  <= step ? emit : (r_s2_v && !out_free);
            r_out_v <= (r_s2_v && out_free) ? 1'b1 : (r_out_v && i_stall);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_kind <= i_kind;
            r_s0_pix  <= i_pixel_value;
        end
    end

    // history memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_idx] <= r_s0_pix;
        end
        if (step) begin
            r_s2_mem <= mem[rd_addr];
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s2_mode     <= mode_c;
            r_s2_pix      <= r_s0_pix;
            r_s2_in_frame <= in_frame;
            r_s2_last     <= last_c;
            // zero offset reads the slot being written in the same cycle
            r_s2_fwd      <= (r_k == '0);
        end
    end

    // pick own and partner pixels
    always_comb begin
        own       = '0;
        partner   = '0;
        diff_live = 1'b0;
        unique case (r_s2_mode)
            shid_pkg::MODE_BEHIND: begin
                own       = r_s2_pix;
                partner   = r_s2_mem;
                diff_live = 1'b1;
            end
            shid_pkg::MODE_AHEAD: begin
                own       = r_s2_fwd ? r_s2_pix : r_s2_mem;
                partner   = r_s2_pix;
                diff_live = 1'b1;
            end
            shid_pkg::MODE_OVF,
            shid_pkg::MODE_DRAIN: begin
                diff_live = 1'b0;
            end
            default: begin
                diff_live = 1'b0;
            end
        endcase
    end

    assign diff_c = (diff_live && r_s2_in_frame && partner != '0)
                  ? ((PIXEL_BITS + 1)'(own) - (PIXEL_BITS + 1)'(partner))
                  : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (r_s2_v && out_free) begin
            r_out_diff <= diff_c;
            r_out_last <= r_s2_last;
            r_out_ovf  <= (r_s2_mode == shid_pkg::MODE_OVF);
        end
    end

    assign o_valid           = r_out_v;
    assign o_difference      = r_out_diff;
    assign o_frame_last      = r_out_last;
    assign o_offset_overflow = r_out_ovf;

    // checks
    `SHID_ASSERT_IMP(a_cnt_idle, i_clk, i_rst_n, r_ovf || r_neg, r_cnt == '0)
    `SHID_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, !r_ovf && !r_neg, r_cnt <= r_k)
    `SHID_ASSERT_IMP(a_wr_wrap, i_clk, i_rst_n, 1'b1, r_wr_idx <= LAST_SLOT)
    `SHID_ASSERT_IMP(a_ovf_zero, i_clk, i_rst_n, o_valid && o_offset_overflow, o_difference == '0)
    `SHID_ASSERT_NXT(a_s0_hold, i_clk, i_rst_n, r_s0_v && !step, r_s0_v && $stable(r_s0_pix))

endmodule

`default_nettype wire
